// ===== rtl/packed_code_threshold_count_defines.svh =====
// Assertion macros shared by the packed code threshold count modules.
`ifndef PACKED_CODE_THRESHOLD_COUNT_DEFINES_SVH
`define PACKED_CODE_THRESHOLD_COUNT_DEFINES_SVH

// Checks cons in the same cycle whenever ante holds.
`define PCTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks cons in the cycle after ante holds.
`define PCTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pctc_pkg.sv =====
// Shared types and constants for the packed code threshold count block.
`timescale 1ns / 1ps
package pctc_pkg;

    localparam int WORD_WIDTH      = 64;
    localparam int CNT_WIDTH       = 24;
    localparam int THR_WIDTH       = 13;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int POP_GROUP       = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_THRESHOLD     = 2'd0,
        REG_ELEMENT_COUNT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== rtl/packed_code_threshold_count.sv =====
// Top level of the packed code threshold count block.
`timescale 1ns / 1ps
// Counts how many of the first element_count codes in a column of CODE_WIDTH-bit codes,
// packed LSB-first into 64-bit words, are strictly below threshold. One word is taken per
// cycle while the lane queue is not full; the front end splits each word, plus the bits
// left over from the previous one, into code lanes in the cycle it is accepted, and a
// two-entry queue feeds a two-stage counting back end. A word flagged last_word produces
// one match_count beat, which passes the lane queue, the first counting stage and the
// result queue, and the scan state then starts over for the next column. Words that are
// not last produce no beat. Leftover bits of a last word are dropped. Write threshold and
// element_count only while no column result is outstanding; cfg_ready is always high.
module packed_code_threshold_count #(
    parameter int CODE_WIDTH = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [pctc_pkg::WORD_WIDTH-1:0]      packed_word,
    input  logic                                 last_word,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [pctc_pkg::CNT_WIDTH-1:0]       match_count,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pctc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pctc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import pctc_pkg::*;

    localparam int LANES = (WORD_WIDTH - 1) / CODE_WIDTH + 1;

    fifo_status_t         mid_status;
    fifo_status_t         res_status;
    logic [LANES-1:0]     hits;
    logic [LANES:0]       mid_rdata;
    logic                 mid_pop;
    logic                 accept;
    logic                 res_push;
    logic [CNT_WIDTH-1:0] res_count;

    assign accept    = push && !mid_status.full;
    assign full      = mid_status.full;
    assign empty     = res_status.empty;
    assign cfg_ready = 1'b1;

    pctc_front #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .packed_word (packed_word),
        .last_word   (last_word),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .hits        (hits)
    );

    pctc_fifo #(
        .WIDTH (LANES + 1),
        .DEPTH (2)
    ) u_mid_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept),
        .wdata  ({last_word, hits}),
        .pop    (mid_pop),
        .rdata  (mid_rdata),
        .status (mid_status)
    );

    pctc_back #(
        .LANES (LANES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_status (mid_status),
        .mid_hits   (mid_rdata[LANES-1:0]),
        .mid_last   (mid_rdata[LANES]),
        .mid_pop    (mid_pop),
        .res_status (res_status),
        .res_push   (res_push),
        .res_count  (res_count)
    );

    pctc_fifo #(
        .WIDTH (CNT_WIDTH),
        .DEPTH (2)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .wdata  (res_count),
        .pop    (pop),
        .rdata  (match_count),
        .status (res_status)
    );

endmodule

// ===== rtl/pctc_fifo.sv =====
// Small register-based queue with full and empty status.
`timescale 1ns / 1ps
module pctc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output pctc_pkg::fifo_status_t status
);
    import pctc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/pctc_front.sv =====
// Front end: joins carried bits with each word, splits codes into lanes and flags matches.
`timescale 1ns / 1ps
`include "packed_code_threshold_count_defines.svh"
module pctc_front #(
    parameter  int CODE_WIDTH = 12,
    localparam int LANES      = (pctc_pkg::WORD_WIDTH - 1) / CODE_WIDTH + 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [pctc_pkg::WORD_WIDTH-1:0]      packed_word,
    input  logic                                 last_word,
    input  logic                                 cfg_write,
    input  logic [pctc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pctc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output logic [LANES-1:0]                     hits
);
    import pctc_pkg::*;

    localparam int CARRY_W = (CODE_WIDTH > 1) ? CODE_WIDTH - 1 : 1;
    localparam int LEN_W   = (CODE_WIDTH > 1) ? $clog2(CODE_WIDTH) : 1;
    localparam int COMB_W  = WORD_WIDTH + CARRY_W;
    localparam int TOT_W   = $clog2(COMB_W + 1);
    localparam int N_W     = $clog2(LANES + 1);
    localparam int CMP_W   = (CODE_WIDTH > THR_WIDTH) ? CODE_WIDTH : THR_WIDTH;

    logic [THR_WIDTH-1:0] threshold_reg;
    logic [CNT_WIDTH-1:0] element_count_reg;
    logic [CARRY_W-1:0]   carry_bits_reg;
    logic [CARRY_W-1:0]   carry_bits_next;
    logic [LEN_W-1:0]     carry_len_reg;
    logic [LEN_W-1:0]     carry_len_next;
    logic [CNT_WIDTH-1:0] codes_seen_reg;
    logic [CNT_WIDTH-1:0] codes_seen_next;

    logic [COMB_W-1:0]    combined;
    logic [COMB_W-1:0]    leftover;
    logic [TOT_W-1:0]     total;
    logic [TOT_W-1:0]     cut;
    logic [CNT_WIDTH-1:0] remaining;
    logic [LANES-1:0]     lane_full;
    logic [N_W-1:0]       n_codes;
    logic [N_W-1:0]       taken;

    // The carried bits sit below the new word, so codes start at bit zero.
    assign combined  = ({{CARRY_W{1'b0}}, packed_word} << carry_len_reg)
                     | {{WORD_WIDTH{1'b0}}, carry_bits_reg};
    assign total     = TOT_W'(WORD_WIDTH) + TOT_W'(carry_len_reg);
    assign remaining = (codes_seen_reg < element_count_reg)
                     ? element_count_reg - codes_seen_reg : '0;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            logic [CODE_WIDTH-1:0] code;
            assign code         = combined[g*CODE_WIDTH +: CODE_WIDTH];
            assign lane_full[g] = (total >= TOT_W'((g + 1) * CODE_WIDTH));
            assign hits[g]      = lane_full[g] && (remaining > CNT_WIDTH'(g))
                                && (CMP_W'(code) < CMP_W'(threshold_reg));
        end
    endgenerate

    // Complete lanes form a thermometer; the highest one sets the cut point.
    always_comb
    begin
        n_codes = '0;
        cut     = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (lane_full[i])
            begin
                n_codes = N_W'(i + 1);
                cut     = TOT_W'((i + 1) * CODE_WIDTH);
            end
        end
    end

    assign leftover        = combined >> cut;
    assign carry_bits_next = leftover[CARRY_W-1:0];
    assign carry_len_next  = LEN_W'(total - cut);
    assign taken           = (remaining < CNT_WIDTH'(n_codes)) ? remaining[N_W-1:0] : n_codes;
    assign codes_seen_next = codes_seen_reg + CNT_WIDTH'(taken);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= '0;
            element_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:     threshold_reg     <= cfg_data[THR_WIDTH-1:0];
                REG_ELEMENT_COUNT: element_count_reg <= cfg_data[CNT_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bits_reg <= '0;
            carry_len_reg  <= '0;
            codes_seen_reg <= '0;
        end
        else if (accept)
        begin
            if (last_word)
            begin
                carry_bits_reg <= '0;
                carry_len_reg  <= '0;
                codes_seen_reg <= '0;
            end
            else
            begin
                carry_bits_reg <= carry_bits_next;
                carry_len_reg  <= carry_len_next;
                codes_seen_reg <= codes_seen_next;
            end
        end
    end

    `PCTC_ASSERT_NOW(a_carry_len_range, 1'b1,
        {1'b0, carry_len_reg} < (LEN_W + 1)'(CODE_WIDTH), "carry length reached code width")
    `PCTC_ASSERT_NEXT(a_last_clears_scan, accept && last_word,
        carry_len_reg == '0 && codes_seen_reg == '0, "scan state not cleared after last beat")

endmodule

// ===== rtl/pctc_back.sv =====
// Back end: counts flagged lanes, accumulates the column total and emits it on the last word.
`timescale 1ns / 1ps
`include "packed_code_threshold_count_defines.svh"
module pctc_back #(
    parameter int LANES = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pctc_pkg::fifo_status_t         mid_status,
    input  logic [LANES-1:0]               mid_hits,
    input  logic                           mid_last,
    output logic                           mid_pop,
    input  pctc_pkg::fifo_status_t         res_status,
    output logic                           res_push,
    output logic [pctc_pkg::CNT_WIDTH-1:0] res_count
);
    import pctc_pkg::*;

    localparam int GROUPS = (LANES + POP_GROUP - 1) / POP_GROUP;
    localparam int GRP_W  = $clog2(POP_GROUP + 1);
    localparam int SUM_W  = $clog2(LANES + 1);

    logic [GRP_W-1:0]            part_reg  [GROUPS];
    logic [GRP_W-1:0]            part_next [GROUPS];
    logic                        s1_last_reg;
    logic                        s1_valid_reg;
    logic [GROUPS*POP_GROUP-1:0] hits_pad;
    logic [SUM_W-1:0]            batch;
    logic [CNT_WIDTH-1:0]        running_count_reg;
    logic [CNT_WIDTH-1:0]        total_count;
    logic                        fire;
    logic                        load;

    assign hits_pad = (GROUPS * POP_GROUP)'(mid_hits);

    // First stage: population count in groups of eight lanes.
    always_comb
    begin
        for (int j = 0; j < GROUPS; j++)
        begin
            part_next[j] = '0;
            for (int k = 0; k < POP_GROUP; k++)
            begin
                part_next[j] = part_next[j] + GRP_W'(hits_pad[j*POP_GROUP + k]);
            end
        end
    end

    always_comb
    begin
        batch = '0;
        for (int j = 0; j < GROUPS; j++)
        begin
            batch = batch + SUM_W'(part_reg[j]);
        end
    end

    assign total_count = running_count_reg + CNT_WIDTH'(batch);
    assign fire        = s1_valid_reg && (!s1_last_reg || !res_status.full);
    assign load        = !mid_status.empty && (!s1_valid_reg || fire);
    assign mid_pop     = load;
    assign res_push    = fire && s1_last_reg;
    assign res_count   = total_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            running_count_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                running_count_reg <= s1_last_reg ? '0 : total_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            part_reg    <= part_next;
            s1_last_reg <= mid_last;
        end
    end

    `PCTC_ASSERT_NEXT(a_running_cleared, fire && s1_last_reg,
        running_count_reg == '0, "running count not cleared after last beat")
    `PCTC_ASSERT_NOW(a_no_push_when_full, res_push, !res_status.full,
        "result pushed into a full queue")
    `PCTC_ASSERT_NOW(a_pop_needs_data, mid_pop, !mid_status.empty,
        "popped an empty lane queue")

endmodule
